FILE: rtl/core/wcr_pkg.sv
// ----------------------------------------------------------------------------
// wcr_pkg: shared types and functions of the contrast ratio unit
// Holds the sRGB linearization table builder and the table type.
// ----------------------------------------------------------------------------
`default_nettype none

package wcr_pkg;

    // widest table entry: 2^24 needs 25 bits
    localparam int unsigned LIN_MAX_W = 25;
    localparam int unsigned BIG_W     = 384;
    localparam int unsigned LIN_DEPTH = 256;

    typedef logic [LIN_DEPTH-1:0][LIN_MAX_W-1:0] t_lin_table;

    // entry = round(((1000*i + 14025)/269025)^(12/5) * 2^f), exact integer search;
    // dark end of the curve is the straight segment i/(255*12.92)
    function automatic t_lin_table lin_table_build(input int unsigned frac_bits);
        t_lin_table          tab;
        logic [BIG_W-1:0]    dpow;
        logic [BIG_W-1:0]    rhs;
        logic [BIG_W-1:0]    lhs;
        longint unsigned     num;
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         mid;
        tab  = '0;
        dpow = BIG_W'(1);
        for (int k = 0; k < 12; k++) begin
            dpow = dpow * BIG_W'(269025);
        end
        for (int i = 0; i < LIN_DEPTH; i++) begin
            if (i <= 10) begin
                num    = (longint'(i) * 100) << (frac_bits + 1);
                tab[i] = LIN_MAX_W'((num + 64'd329460) / 64'd658920);
            end else begin
                rhs = BIG_W'(1);
                for (int k = 0; k < 12; k++) begin
                    rhs = rhs * BIG_W'(1000 * i + 14025);
                end
                rhs = rhs << (5 * frac_bits + 5);
                lo  = 0;
                hi  = 1 << frac_bits;
                while (lo < hi) begin
                    mid = lo + ((hi - lo + 1) >> 1);
                    lhs = dpow;
                    for (int k = 0; k < 5; k++) begin
                        lhs = lhs * BIG_W'(2 * mid - 1);
                    end
                    if (lhs <= rhs) begin
                        lo = mid;
                    end else begin
                        hi = mid - 1;
                    end
                end
                tab[i] = LIN_MAX_W'(lo);
            end
        end
        return tab;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/wcr_front.sv
// ----------------------------------------------------------------------------
// wcr_front: compositing, linearization and luminance pipeline
// Six stages that turn one color set into the dividend and divisor of the ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module wcr_front #(
    parameter int unsigned LINEAR_FRACTION_BITS = 16,
    parameter int unsigned RATIO_FRACTION_BITS  = 11,
    parameter int unsigned NW                   = 45,
    parameter int unsigned DW                   = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_text_red,
    input  wire logic [7:0]    i_text_green,
    input  wire logic [7:0]    i_text_blue,
    input  wire logic [7:0]    i_surface_red,
    input  wire logic [7:0]    i_surface_green,
    input  wire logic [7:0]    i_surface_blue,
    input  wire logic [7:0]    i_surface_alpha,
    input  wire logic [7:0]    i_ground_red,
    input  wire logic [7:0]    i_ground_green,
    input  wire logic [7:0]    i_ground_blue,
    input  wire logic          i_blend,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [NW-1:0]      o_num,
    output logic [DW-1:0]      o_den,
    output logic [7:0]         o_shown_red,
    output logic [7:0]         o_shown_green,
    output logic [7:0]         o_shown_blue
);
    import wcr_pkg::*;

    localparam int unsigned LW = LINEAR_FRACTION_BITS + 1;
    localparam int unsigned YW = LINEAR_FRACTION_BITS + 14;
    localparam t_lin_table LinTable = lin_table_build(LINEAR_FRACTION_BITS);

    logic [6:1] r_v;
    logic [6:1] w_adv;

    // stage 1: blend sums
    logic [7:0]  r1_tr, r1_tg, r1_tb, r1_sr, r1_sg, r1_sb;
    logic        r1_blend;
    logic [15:0] r1_xr, r1_xg, r1_xb;
    // stage 2: shown color
    logic [7:0]  r2_tr, r2_tg, r2_tb, r2_sr, r2_sg, r2_sb;
    // stage 3: linear values
    logic [LW-1:0] r3_ltr, r3_ltg, r3_ltb, r3_lsr, r3_lsg, r3_lsb;
    logic [7:0]    r3_sr, r3_sg, r3_sb;
    // stage 4: weighted terms
    logic [YW-1:0] r4_ptr, r4_ptg, r4_ptb, r4_psr, r4_psg, r4_psb;
    logic [7:0]    r4_sr, r4_sg, r4_sb;
    // stage 5: luminances
    logic [YW-1:0] r5_lt, r5_ls;
    logic [7:0]    r5_sr, r5_sg, r5_sb;
    // stage 6: dividend and divisor
    logic [NW-1:0] r6_num;
    logic [DW-1:0] r6_den;
    logic [7:0]    r6_sr, r6_sg, r6_sb;

    logic [15:0]   w_xr, w_xg, w_xb;
    logic [16:0]   w_tr, w_tg, w_tb;
    logic [7:0]    w_cr, w_cg, w_cb;
    logic [YW-1:0] w_hi, w_lo, w_off;

    always_comb begin
        w_adv[6] = !r_v[6] || i_ready;
        w_adv[5] = !r_v[5] || w_adv[6];
        w_adv[4] = !r_v[4] || w_adv[5];
        w_adv[3] = !r_v[3] || w_adv[4];
        w_adv[2] = !r_v[2] || w_adv[3];
        w_adv[1] = !r_v[1] || w_adv[2];
    end

    assign o_ready = w_adv[1];
    assign o_valid = r_v[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[1]) r_v[1] <= i_valid;
            if (w_adv[2]) r_v[2] <= r_v[1];
            if (w_adv[3]) r_v[3] <= r_v[2];
            if (w_adv[4]) r_v[4] <= r_v[3];
            if (w_adv[5]) r_v[5] <= r_v[4];
            if (w_adv[6]) r_v[6] <= r_v[5];
        end
    end

    // alpha*surface + (255-alpha)*ground
    always_comb begin
        w_xr = ({8'd0, i_surface_alpha} * {8'd0, i_surface_red})
             + ({8'd0, 8'd255 - i_surface_alpha} * {8'd0, i_ground_red});
        w_xg = ({8'd0, i_surface_alpha} * {8'd0, i_surface_green})
             + ({8'd0, 8'd255 - i_surface_alpha} * {8'd0, i_ground_green});
        w_xb = ({8'd0, i_surface_alpha} * {8'd0, i_surface_blue})
             + ({8'd0, 8'd255 - i_surface_alpha} * {8'd0, i_ground_blue});
    end

    // rounded divide by 255, exact for sums up to 255*255
    always_comb begin
        w_tr = {1'b0, r1_xr} + 17'd128;
        w_tg = {1'b0, r1_xg} + 17'd128;
        w_tb = {1'b0, r1_xb} + 17'd128;
        w_cr = 8'((w_tr + (w_tr >> 8)) >> 8);
        w_cg = 8'((w_tg + (w_tg >> 8)) >> 8);
        w_cb = 8'((w_tb + (w_tb >> 8)) >> 8);
    end

    always_comb begin
        w_off = YW'(500) << LINEAR_FRACTION_BITS;
        if (r5_lt > r5_ls) begin
            w_hi = r5_lt;
            w_lo = r5_ls;
        end else begin
            w_hi = r5_ls;
            w_lo = r5_lt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1] && i_valid) begin
            r1_tr    <= i_text_red;
            r1_tg    <= i_text_green;
            r1_tb    <= i_text_blue;
            r1_sr    <= i_surface_red;
            r1_sg    <= i_surface_green;
            r1_sb    <= i_surface_blue;
            r1_blend <= i_blend;
            r1_xr    <= w_xr;
            r1_xg    <= w_xg;
            r1_xb    <= w_xb;
        end
        if (w_adv[2] && r_v[1]) begin
            r2_tr <= r1_tr;
            r2_tg <= r1_tg;
            r2_tb <= r1_tb;
            r2_sr <= r1_blend ? w_cr : r1_sr;
            r2_sg <= r1_blend ? w_cg : r1_sg;
            r2_sb <= r1_blend ? w_cb : r1_sb;
        end
        if (w_adv[3] && r_v[2]) begin
            r3_ltr <= LinTable[r2_tr][LW-1:0];
            r3_ltg <= LinTable[r2_tg][LW-1:0];
            r3_ltb <= LinTable[r2_tb][LW-1:0];
            r3_lsr <= LinTable[r2_sr][LW-1:0];
            r3_lsg <= LinTable[r2_sg][LW-1:0];
            r3_lsb <= LinTable[r2_sb][LW-1:0];
            r3_sr  <= r2_sr;
            r3_sg  <= r2_sg;
            r3_sb  <= r2_sb;
        end
        if (w_adv[4] && r_v[3]) begin
            r4_ptr <= YW'(2126) * YW'(r3_ltr);
            r4_ptg <= YW'(7152) * YW'(r3_ltg);
            r4_ptb <= YW'(722) * YW'(r3_ltb);
            r4_psr <= YW'(2126) * YW'(r3_lsr);
            r4_psg <= YW'(7152) * YW'(r3_lsg);
            r4_psb <= YW'(722) * YW'(r3_lsb);
            r4_sr  <= r3_sr;
            r4_sg  <= r3_sg;
            r4_sb  <= r3_sb;
        end
        if (w_adv[5] && r_v[4]) begin
            r5_lt <= r4_ptr + r4_ptg + r4_ptb;
            r5_ls <= r4_psr + r4_psg + r4_psb;
            r5_sr <= r4_sr;
            r5_sg <= r4_sg;
            r5_sb <= r4_sb;
        end
        if (w_adv[6] && r_v[5]) begin
            // 2*(hi+off)<<ratio_bits plus (lo+off), over 2*(lo+off): rounded ratio
            r6_num <= (NW'(w_hi + w_off) << (RATIO_FRACTION_BITS + 1)) + NW'(w_lo + w_off);
            r6_den <= DW'(w_lo + w_off) << 1;
            r6_sr  <= r5_sr;
            r6_sg  <= r5_sg;
            r6_sb  <= r5_sb;
        end
    end

    assign o_num         = r6_num;
    assign o_den         = r6_den;
    assign o_shown_red   = r6_sr;
    assign o_shown_green = r6_sg;
    assign o_shown_blue  = r6_sb;

endmodule

`default_nettype wire

FILE: rtl/core/wcr_div_cell.sv
// ----------------------------------------------------------------------------
// wcr_div_cell: one restoring division step
// Settles one quotient bit and passes the partial remainder to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wcr_div_cell #(
    parameter int unsigned NW  = 45,
    parameter int unsigned DW  = 31,
    parameter int unsigned QW  = 16,
    parameter int unsigned BIT = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [NW-1:0] i_rem,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [QW-1:0] i_quo,
    input  wire logic [7:0]    i_shown_red,
    input  wire logic [7:0]    i_shown_green,
    input  wire logic [7:0]    i_shown_blue,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [NW-1:0]      o_rem,
    output logic [DW-1:0]      o_den,
    output logic [QW-1:0]      o_quo,
    output logic [7:0]         o_shown_red,
    output logic [7:0]         o_shown_green,
    output logic [7:0]         o_shown_blue
);
    import wcr_pkg::*;

    localparam int unsigned CW = DW + QW;

    logic          r_v;
    logic [NW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_quo;
    logic [7:0]    r_sr, r_sg, r_sb;
    logic          w_adv;
    logic [CW-1:0] w_sub;
    logic          w_ge;

    assign w_adv   = !r_v || i_ready;
    assign o_ready = w_adv;
    assign w_sub   = CW'(i_den) << BIT;
    assign w_ge    = CW'(i_rem) >= w_sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_rem <= w_ge ? NW'(CW'(i_rem) - w_sub) : i_rem;
            r_den <= i_den;
            r_quo <= i_quo | (QW'(w_ge) << BIT);
            r_sr  <= i_shown_red;
            r_sg  <= i_shown_green;
            r_sb  <= i_shown_blue;
        end
    end

    assign o_valid       = r_v;
    assign o_rem         = r_rem;
    assign o_den         = r_den;
    assign o_quo         = r_quo;
    assign o_shown_red   = r_sr;
    assign o_shown_green = r_sg;
    assign o_shown_blue  = r_sb;

endmodule

`default_nettype wire

FILE: rtl/core/wcr_out_stage.sv
// ----------------------------------------------------------------------------
// wcr_out_stage: result register
// Clamps the quotient to 16 bits and holds the result item for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module wcr_out_stage #(
    parameter int unsigned NW = 45,
    parameter int unsigned QW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [NW-1:0] i_rem,
    input  wire logic [QW-1:0] i_quo,
    input  wire logic [7:0]    i_shown_red,
    input  wire logic [7:0]    i_shown_green,
    input  wire logic [7:0]    i_shown_blue,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [15:0]        o_contrast_q,
    output logic [7:0]         o_shown_red,
    output logic [7:0]         o_shown_green,
    output logic [7:0]         o_shown_blue,
    output logic               o_exact
);
    import wcr_pkg::*;

    logic        r_v;
    logic [15:0] r_q;
    logic [7:0]  r_sr, r_sg, r_sb;
    logic        r_exact;
    logic        w_adv;
    logic        w_sat;

    assign w_adv   = !r_v || i_ready;
    assign o_ready = w_adv;
    assign w_sat   = |(i_quo >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_q     <= w_sat ? 16'hFFFF : 16'(i_quo);
            r_sr    <= i_shown_red;
            r_sg    <= i_shown_green;
            r_sb    <= i_shown_blue;
            // ratio landed exactly on a quotient step
            r_exact <= (i_rem == '0);
        end
    end

    assign o_valid       = r_v;
    assign o_contrast_q  = r_q;
    assign o_shown_red   = r_sr;
    assign o_shown_green = r_sg;
    assign o_shown_blue  = r_sb;
    assign o_exact       = r_exact;

endmodule

`default_nettype wire

FILE: rtl/core/wcag_contrast_ratio_unit.sv
// ----------------------------------------------------------------------------
// wcag_contrast_ratio_unit: contrast ratio of text over an optionally blended surface
// Input channel carries text, surface, alpha, ground and the blend flag; the
// output channel carries the Q5.11 contrast ratio and the surface color compared.
// Both channels are valid/ready; an item moves when valid and ready are high.
// One item is accepted per clock while the pipeline has room (o_ready high).
// The path holds six front stages (blend, divide by 255, sRGB table, weights,
// sums, offset and ordering), one restoring divider cell per quotient bit
// (RATIO_FRACTION_BITS + 5 cells), and a result register.
// Every stage has its own valid bit and moves when its successor has room, so
// bubbles close up and new items are taken while a result waits to be read.
// A stalled receiver fills the pipeline, after which o_ready drops.
// Reset clears all valid bits; the linearization table is a constant and
// needs no fill.
// ----------------------------------------------------------------------------
`default_nettype none

module wcag_contrast_ratio_unit #(
    parameter int unsigned LINEAR_FRACTION_BITS = 16,
    parameter int unsigned RATIO_FRACTION_BITS  = 11
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_text_red,
    input  wire logic [7:0] i_text_green,
    input  wire logic [7:0] i_text_blue,
    input  wire logic [7:0] i_surface_red,
    input  wire logic [7:0] i_surface_green,
    input  wire logic [7:0] i_surface_blue,
    input  wire logic [7:0] i_surface_alpha,
    input  wire logic [7:0] i_ground_red,
    input  wire logic [7:0] i_ground_green,
    input  wire logic [7:0] i_ground_blue,
    input  wire logic       i_blend,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [15:0]     o_contrast_q,
    output logic [7:0]      o_shown_red,
    output logic [7:0]      o_shown_green,
    output logic [7:0]      o_shown_blue
);
    import wcr_pkg::*;

    localparam int unsigned YW = LINEAR_FRACTION_BITS + 14;
    localparam int unsigned NW = YW + RATIO_FRACTION_BITS + 2;
    localparam int unsigned DW = YW + 1;
    localparam int unsigned QW = RATIO_FRACTION_BITS + 5;

    logic [QW:0]   w_v;
    logic [QW:0]   w_rdy;
    logic [NW-1:0] w_rem [QW+1];
    logic [DW-1:0] w_den [QW+1];
    logic [QW-1:0] w_quo [QW+1];
    logic [7:0]    w_sr  [QW+1];
    logic [7:0]    w_sg  [QW+1];
    logic [7:0]    w_sb  [QW+1];
    logic          w_exact;

    wcr_front #(
        .LINEAR_FRACTION_BITS (LINEAR_FRACTION_BITS),
        .RATIO_FRACTION_BITS  (RATIO_FRACTION_BITS),
        .NW                   (NW),
        .DW                   (DW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_text_red      (i_text_red),
        .i_text_green    (i_text_green),
        .i_text_blue     (i_text_blue),
        .i_surface_red   (i_surface_red),
        .i_surface_green (i_surface_green),
        .i_surface_blue  (i_surface_blue),
        .i_surface_alpha (i_surface_alpha),
        .i_ground_red    (i_ground_red),
        .i_ground_green  (i_ground_green),
        .i_ground_blue   (i_ground_blue),
        .i_blend         (i_blend),
        .o_valid         (w_v[0]),
        .i_ready         (w_rdy[0]),
        .o_num           (w_rem[0]),
        .o_den           (w_den[0]),
        .o_shown_red     (w_sr[0]),
        .o_shown_green   (w_sg[0]),
        .o_shown_blue    (w_sb[0])
    );

    assign w_quo[0] = '0;

    // cell k settles quotient bit QW-1-k
    for (genvar k = 0; k < QW; k++) begin : g_cell
        wcr_div_cell #(
            .NW  (NW),
            .DW  (DW),
            .QW  (QW),
            .BIT (QW - 1 - k)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_valid       (w_v[k]),
            .o_ready       (w_rdy[k]),
            .i_rem         (w_rem[k]),
            .i_den         (w_den[k]),
            .i_quo         (w_quo[k]),
            .i_shown_red   (w_sr[k]),
            .i_shown_green (w_sg[k]),
            .i_shown_blue  (w_sb[k]),
            .o_valid       (w_v[k+1]),
            .i_ready       (w_rdy[k+1]),
            .o_rem         (w_rem[k+1]),
            .o_den         (w_den[k+1]),
            .o_quo         (w_quo[k+1]),
            .o_shown_red   (w_sr[k+1]),
            .o_shown_green (w_sg[k+1]),
            .o_shown_blue  (w_sb[k+1])
        );
    end

    wcr_out_stage #(
        .NW (NW),
        .QW (QW)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_v[QW]),
        .o_ready       (w_rdy[QW]),
        .i_rem         (w_rem[QW]),
        .i_quo         (w_quo[QW]),
        .i_shown_red   (w_sr[QW]),
        .i_shown_green (w_sg[QW]),
        .i_shown_blue  (w_sb[QW]),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_contrast_q  (o_contrast_q),
        .o_shown_red   (o_shown_red),
        .o_shown_green (o_shown_green),
        .o_shown_blue  (o_shown_blue),
        .o_exact       (w_exact)
    );

    // divisor of the last cell is not needed past the chain
    logic w_unused;
    assign w_unused = w_exact ^ (|w_den[QW]);

endmodule

`default_nettype wire
